// ===== rtl/leb_pkg.sv =====
package leb_pkg;

  // fixed field widths
  localparam int KEY_W     = 9;
  localparam int CODE_W    = 8;
  localparam int DEST_W    = 2;
  localparam int LEN_W     = 5;
  localparam int CFG_IDX_W = 8;

  // default line capacity
  localparam int MAX_LINE_DEF = 31;

  // fixed key codes
  localparam logic [KEY_W-1:0] KEY_NEWLINE   = 9'd10;
  localparam logic [KEY_W-1:0] KEY_BACKSPACE = 9'd8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_CODE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_CODE = 8'd1;

  // register reset values
  localparam logic [CODE_W-1:0] LEFT_CODE_RST  = 8'd1;
  localparam logic [CODE_W-1:0] RIGHT_CODE_RST = 8'd2;

  typedef enum logic [DEST_W-1:0] {
    DEST_ECHO     = 2'd0,
    DEST_CONSUMER = 2'd1,
    DEST_DROP     = 2'd2
  } dest_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ECHO_RIGHT,
    S_ECHO_NL,
    S_FLUSH_RD,
    S_FLUSH_EMIT,
    S_FLUSH_NL,
    S_BS_RD,
    S_BS_WR,
    S_INS_RD,
    S_INS_WR
  } state_t;

  // cursor key codes handed to the sequencer
  typedef struct packed {
    logic [CODE_W-1:0] left;
    logic [CODE_W-1:0] right;
  } codes_t;

  // 9-bit two's complement of a cursor code
  function automatic logic [KEY_W-1:0] neg_code(input logic [CODE_W-1:0] code);
    logic [KEY_W:0] diff;
    diff = 10'h200 - {2'b00, code};
    return diff[KEY_W-1:0];
  endfunction

endpackage

// ===== rtl/leb_if.sv =====
// key channel
interface leb_key_if;
  logic                       valid;
  logic                       ready;
  logic [leb_pkg::KEY_W-1:0]  key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

// result channel
interface leb_res_if;
  logic                       valid;
  logic                       ready;
  logic [leb_pkg::DEST_W-1:0] destination;
  logic [leb_pkg::KEY_W-1:0]  value;
  logic                       last;

  modport source (output valid, output destination, output value, output last, input ready);
  modport sink   (input valid, input destination, input value, input last, output ready);
endinterface

// configuration write channel
interface leb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [leb_pkg::CFG_IDX_W-1:0] index;
  logic [leb_pkg::CODE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/leb_ram.sv =====
module leb_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 31
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/leb_ctrl.sv =====
module leb_ctrl #(
  parameter int MAX_LINE = leb_pkg::MAX_LINE_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  leb_pkg::codes_t codes,
  leb_key_if.sink         keys,
  leb_res_if.source       results
);
  import leb_pkg::*;

  localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

  state_t state, state_next;

  logic [KEY_W-1:0] key_q;
  logic [LEN_W-1:0] len, len_next;
  logic [LEN_W-1:0] cursor, cursor_next;
  logic [LEN_W-1:0] idx, idx_next;
  logic [LEN_W-1:0] idx_inc, idx_dec;

  // output register
  logic             out_valid;
  dest_t            out_dest;
  logic [KEY_W-1:0] out_value;
  logic             out_last;

  logic             emit;
  dest_t            emit_dest;
  logic [KEY_W-1:0] emit_value;
  logic             emit_last;

  // line store port signals
  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [KEY_W-1:0] wdata, rdata;

  // decode and status
  logic is_left, is_right, is_nl, is_bs;
  logic slot, left_ok, right_ok, more_after, full, ins_more;

  leb_ram #(.WIDTH(KEY_W), .DEPTH(MAX_LINE)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign idx_inc = idx + 1'b1;
  assign idx_dec = idx - 1'b1;

  assign is_left  = (key_q == neg_code(codes.left));
  assign is_right = (key_q == neg_code(codes.right));
  assign is_nl    = (key_q == KEY_NEWLINE);
  assign is_bs    = (key_q == KEY_BACKSPACE);

  assign slot       = !out_valid || results.ready;
  assign left_ok    = (cursor != '0);
  assign right_ok   = (cursor < len);
  assign more_after = ({1'b0, idx} + 1'b1) < {1'b0, len};
  assign full       = (len >= LEN_W'(MAX_LINE));
  assign ins_more   = (idx > cursor);

  assign keys.ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (keys.valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (is_left) begin
          if (!left_ok || slot) state_next = S_IDLE;
        end else if (is_right) begin
          if (!right_ok || slot) state_next = S_IDLE;
        end else if (is_nl) begin
          state_next = S_ECHO_RIGHT;
        end else if (is_bs) begin
          if (!left_ok) state_next = S_IDLE;
          else if (slot) state_next = S_BS_RD;
        end else if (slot) begin
          state_next = full ? S_IDLE : S_INS_RD;
        end
      end
      S_ECHO_RIGHT: begin
        if (!right_ok) state_next = S_ECHO_NL;
      end
      S_ECHO_NL: begin
        if (slot) state_next = (len != '0) ? S_FLUSH_RD : S_FLUSH_NL;
      end
      S_FLUSH_RD: state_next = S_FLUSH_EMIT;
      S_FLUSH_EMIT: begin
        if (slot && !more_after) state_next = S_FLUSH_NL;
      end
      S_FLUSH_NL: begin
        if (slot) state_next = S_IDLE;
      end
      S_BS_RD:  state_next = more_after ? S_BS_WR : S_IDLE;
      S_BS_WR:  state_next = S_BS_RD;
      S_INS_RD: state_next = ins_more ? S_INS_WR : S_IDLE;
      S_INS_WR: state_next = S_INS_RD;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs, store accesses and counter updates
  always_comb begin
    emit        = 1'b0;
    emit_dest   = DEST_ECHO;
    emit_value  = key_q;
    emit_last   = 1'b0;
    we          = 1'b0;
    waddr       = idx[AW-1:0];
    wdata       = rdata;
    re          = 1'b0;
    raddr       = idx[AW-1:0];
    cursor_next = cursor;
    len_next    = len;
    idx_next    = idx;
    case (state)
      S_DISPATCH: begin
        if (is_left) begin
          if (left_ok && slot) begin
            emit        = 1'b1;
            emit_value  = neg_code(codes.left);
            emit_last   = 1'b1;
            cursor_next = cursor - 1'b1;
          end
        end else if (is_right) begin
          if (right_ok && slot) begin
            emit        = 1'b1;
            emit_value  = neg_code(codes.right);
            emit_last   = 1'b1;
            cursor_next = cursor + 1'b1;
          end
        end else if (is_nl) begin
          idx_next = '0;
        end else if (is_bs) begin
          if (left_ok && slot) begin
            emit        = 1'b1;
            emit_value  = KEY_BACKSPACE;
            emit_last   = 1'b1;
            cursor_next = cursor - 1'b1;
            idx_next    = cursor - 1'b1;
          end
        end else if (slot) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          if (full) emit_dest = DEST_DROP;
          else idx_next = len;
        end
      end
      // cursor walks to the end of the line
      S_ECHO_RIGHT: begin
        if (right_ok && slot) begin
          emit        = 1'b1;
          emit_value  = neg_code(codes.right);
          cursor_next = cursor + 1'b1;
        end
      end
      S_ECHO_NL: begin
        if (slot) begin
          emit       = 1'b1;
          emit_value = KEY_NEWLINE;
          idx_next   = '0;
        end
      end
      // first read of the flush
      S_FLUSH_RD: begin
        re = 1'b1;
      end
      // deliver one stored key, fetch the next
      S_FLUSH_EMIT: begin
        if (slot) begin
          emit       = 1'b1;
          emit_dest  = DEST_CONSUMER;
          emit_value = rdata;
          if (more_after) begin
            re       = 1'b1;
            raddr    = idx_inc[AW-1:0];
            idx_next = idx_inc;
          end
        end
      end
      S_FLUSH_NL: begin
        if (slot) begin
          emit        = 1'b1;
          emit_dest   = DEST_CONSUMER;
          emit_value  = KEY_NEWLINE;
          emit_last   = 1'b1;
          len_next    = '0;
          cursor_next = '0;
        end
      end
      // backspace: pull the tail down one entry at a time
      S_BS_RD: begin
        if (more_after) begin
          re    = 1'b1;
          raddr = idx_inc[AW-1:0];
        end else begin
          len_next = len - 1'b1;
        end
      end
      S_BS_WR: begin
        we       = 1'b1;
        idx_next = idx_inc;
      end
      // insert: push the tail up, then store the key at the cursor
      S_INS_RD: begin
        if (ins_more) begin
          re    = 1'b1;
          raddr = idx_dec[AW-1:0];
        end else begin
          we          = 1'b1;
          waddr       = cursor[AW-1:0];
          wdata       = key_q;
          cursor_next = cursor + 1'b1;
          len_next    = len + 1'b1;
        end
      end
      S_INS_WR: begin
        we       = 1'b1;
        idx_next = idx_dec;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      len    <= len_next;
      cursor <= cursor_next;
      if (emit) out_valid <= 1'b1;
      else if (results.ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (keys.valid && keys.ready) key_q <= keys.key;
    if (emit) begin
      out_dest  <= emit_dest;
      out_value <= emit_value;
      out_last  <= emit_last;
    end
  end

  assign results.valid       = out_valid;
  assign results.destination = out_dest;
  assign results.value       = out_value;
  assign results.last        = out_last;

endmodule

// ===== rtl/line_edit_buffer.sv =====
// Line editor with a cursor. Each word on the keys channel is one 9-bit
// signed key code; each word on the results channel carries a destination
// (echo, consumer, drop notice), a key value and a last flag that marks the
// final word caused by one key. A key that causes nothing gives no word.
// The cfg channel writes the left and right cursor codes (index 0 and 1);
// it is always ready and writes to other indexes are ignored.
// One key is taken at a time: keys.ready is high only while the editor is
// idle. A cursor key or a drop is handled in the dispatch state, which
// registers its word in the output register. Insert and backspace move
// each key after the cursor by a read and then a write, since the read
// port of the line store is registered. Newline gives one word per cycle
// while the results channel takes them: right echoes, newline echo, the
// stored keys, then newline, with a state change to leave the right
// echoes and a store read before the first stored key.
// A held-off results channel stalls the sequencer at its next word; one
// finished word waits in the output register meanwhile.
// Synchronous reset empties the line, homes the cursor, drops any pending
// word and restores the cursor codes to 1 and 2; the store is not cleared.
module line_edit_buffer #(
  parameter int MAX_LINE = leb_pkg::MAX_LINE_DEF
) (
  input logic       clk,
  input logic       rst,
  leb_key_if.sink   keys,
  leb_res_if.source results,
  leb_cfg_if.sink   cfg
);
  import leb_pkg::*;

  logic [CODE_W-1:0] left_code, right_code;
  codes_t            codes;

  assign cfg.ready = 1'b1;

  // cursor code registers
  always_ff @(posedge clk) begin
    if (rst) begin
      left_code  <= LEFT_CODE_RST;
      right_code <= RIGHT_CODE_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_LEFT_CODE:  left_code  <= cfg.data;
        REG_RIGHT_CODE: right_code <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  assign codes.left  = left_code;
  assign codes.right = right_code;

  leb_ctrl #(.MAX_LINE(MAX_LINE)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .codes   (codes),
    .keys    (keys),
    .results (results)
  );

endmodule
